@@ sv/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared types, opcodes and status codes of the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned OpW          = 3;
  localparam int unsigned ValW         = 32;
  localparam int unsigned StatW        = 2;
  localparam int unsigned CntW         = 5;

  typedef enum logic [OpW-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_SORT    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_DUMP    = 3'd4
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Payload of one input transfer.
  typedef struct packed {
    logic [OpW-1:0]         opcode;
    logic signed [ValW-1:0] item_value;
  } item_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic signed [ValW-1:0] entry_value;
    logic [StatW-1:0]       status;
    logic [CntW-1:0]        entry_count;
    logic                   last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,   // read entry at scan pointer
    S_SCAN_CMP,  // compare entry with key
    S_SHIFT_RD,  // read entry below shift pointer
    S_SHIFT_WR,  // write it one place up
    S_PLACE,     // write key at found position
    S_SORT_RD,   // fetch key for one insertion sort pass
    S_SORT_KEY,  // latch key
    S_REV_RDA,
    S_REV_RDB,
    S_REV_WRA,
    S_REV_WRB,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load_item;   // latch opcode/value, clear scan pointer, set sort index to one
    logic       rd_scan;     // read at scan pointer
    logic       rd_shift;    // read at shift pointer minus one
    logic       rd_a;        // read at pointer a
    logic       rd_b;        // read at pointer b
    logic       rd_i;        // read at sort index
    logic       key_from_rd; // key takes read data
    logic       tmp_from_rd; // temp takes read data
    logic       wr_shift;    // write read data at shift pointer
    logic       wr_place;    // write key at scan pointer
    logic       wr_a_rd;     // write read data at a
    logic       wr_b_tmp;    // write temp at b
    logic       scan_inc;
    logic       scan_clr;
    logic       shift_from_n;// shift pointer = fill count
    logic       shift_from_i;// shift pointer = sort index
    logic       shift_dec;
    logic       i_inc;
    logic       ab_init;
    logic       ab_step;
    logic       cnt_inc;
    logic       emit;        // present a result
    logic       emit_entry;  // result carries read data
    logic [1:0] emit_status;
    logic       emit_last;
  } slt_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic           full;
    logic           empty;
    logic           scan_done;  // scan pointer reached its limit
    logic           less;       // read entry < key
    logic           shift_done; // shift pointer equals scan pointer
    logic           sort_done;  // sort index reached fill count
    logic           ab_done;    // a >= b, or fewer than two entries
    logic           dump_last;  // scan pointer is the final entry
    logic           out_busy;   // output register still holds a result
  } slt_stat_t;

endpackage

@@ sv/slt_if.sv @@
// ----------------------------------------------------------------------------
// Sorted list table channel
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface slt_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/slt_ram.sv @@
// ----------------------------------------------------------------------------
// Sorted list table RAM
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ sv/slt_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted list table datapath
// Entry memory, pointers, key and temp registers and the result register.
// ----------------------------------------------------------------------------
module slt_datapath #(
  parameter int unsigned Depth = slt_pkg::DefaultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [slt_pkg::OpW-1:0]       opcode_i,
  input  logic signed [slt_pkg::ValW-1:0] item_value_i,
  input  slt_pkg::slt_cmd_t             cmd_i,
  output slt_pkg::slt_stat_t            stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [slt_pkg::ValW-1:0] entry_value_o,
  output logic [slt_pkg::StatW-1:0]     status_o,
  output logic [slt_pkg::CntW-1:0]      entry_count_o,
  output logic                          last_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned PW = $clog2(Depth + 1);

  logic [slt_pkg::OpW-1:0]         op_q;
  logic signed [slt_pkg::ValW-1:0] key_q, tmp_q;
  logic [PW-1:0] n_q, scan_q, shift_q, i_q, a_q, b_q;
  logic [PW-1:0] scan_lim, addr_full;
  logic [AW-1:0] addr;
  logic          we;
  logic signed [slt_pkg::ValW-1:0] wdata, rdata;
  logic out_valid_q;

  // Memory address and write data selection.
  always_comb begin
    addr_full = scan_q;
    wdata     = rdata;
    we        = 1'b0;
    if (cmd_i.rd_shift || cmd_i.wr_shift) begin
      addr_full = cmd_i.wr_shift ? shift_q : shift_q - PW'(1);
      we        = cmd_i.wr_shift;
    end else if (cmd_i.rd_a || cmd_i.wr_a_rd) begin
      addr_full = a_q;
      we        = cmd_i.wr_a_rd;
    end else if (cmd_i.rd_b || cmd_i.wr_b_tmp) begin
      addr_full = b_q;
      we        = cmd_i.wr_b_tmp;
      wdata     = tmp_q;
    end else if (cmd_i.rd_i) begin
      addr_full = i_q;
    end else if (cmd_i.wr_place) begin
      we    = 1'b1;
      wdata = key_q;
    end
    addr = addr_full[AW-1:0];
  end

  slt_ram #(.Width(slt_pkg::ValW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0; scan_q <= '0; shift_q <= '0; i_q <= '0; a_q <= '0; b_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        scan_q <= '0;
        i_q    <= PW'(1);
      end
      if (cmd_i.scan_clr)     scan_q  <= '0;
      if (cmd_i.scan_inc)     scan_q  <= scan_q + PW'(1);
      if (cmd_i.shift_from_n) shift_q <= n_q;
      if (cmd_i.shift_from_i) shift_q <= i_q;
      if (cmd_i.shift_dec)    shift_q <= shift_q - PW'(1);
      if (cmd_i.i_inc)        i_q     <= i_q + PW'(1);
      if (cmd_i.cnt_inc)      n_q     <= n_q + PW'(1);
      if (cmd_i.ab_init) begin
        a_q <= '0;
        b_q <= n_q - PW'(1);
      end
      if (cmd_i.ab_step) begin
        a_q <= a_q + PW'(1);
        b_q <= b_q - PW'(1);
      end
    end
  end

  // Item, key and temp payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= opcode_i;
      key_q <= item_value_i;
    end
    if (cmd_i.key_from_rd) key_q <= rdata;
    if (cmd_i.tmp_from_rd) tmp_q <= rdata;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      entry_value_o <= cmd_i.emit_entry ? rdata : '0;
      status_o      <= cmd_i.emit_status;
      entry_count_o <= slt_pkg::CntW'(n_q + PW'(cmd_i.cnt_inc));
      last_o        <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;

  // Scan limit is the count for inserts, the sort index during sort.
  assign scan_lim = (op_q == slt_pkg::OP_SORT) ? i_q : n_q;

  always_comb begin
    stat_o            = '0;
    stat_o.opcode     = op_q;
    stat_o.full       = (n_q == PW'(Depth));
    stat_o.empty      = (n_q == '0);
    stat_o.scan_done  = (scan_q >= scan_lim);
    stat_o.less       = (rdata < key_q);
    stat_o.shift_done = (shift_q == scan_q);
    stat_o.sort_done  = (i_q >= n_q);
    stat_o.ab_done    = (a_q >= b_q) || (n_q < PW'(2));
    stat_o.dump_last  = (scan_q == n_q - PW'(1));
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end
endmodule

@@ sv/slt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted list table controller
// Sequences memory walks for each operation and issues results.
// ----------------------------------------------------------------------------
module slt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  slt_pkg::slt_stat_t stat_i,
  output slt_pkg::slt_cmd_t  cmd_o
);
  slt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      slt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = slt_pkg::S_RESULT;
        end
      end
      // Decode the latched opcode.
      slt_pkg::S_RESULT: begin
        if (!stat_i.out_busy) begin
          unique case (stat_i.opcode)
            slt_pkg::OP_APPEND: begin
              if (stat_i.full) begin
                cmd_o.emit = 1'b1; cmd_o.emit_status = slt_pkg::ST_FULL;
                cmd_o.emit_last = 1'b1; state_d = slt_pkg::S_IDLE;
              end else begin
                // Shift pointer takes the fill count; scan steps up to it: place at tail.
                cmd_o.shift_from_n = 1'b1;
                state_d = slt_pkg::S_SCAN_RD;
              end
            end
            slt_pkg::OP_INSERT: begin
              if (stat_i.full) begin
                cmd_o.emit = 1'b1; cmd_o.emit_status = slt_pkg::ST_FULL;
                cmd_o.emit_last = 1'b1; state_d = slt_pkg::S_IDLE;
              end else begin
                cmd_o.shift_from_n = 1'b1;
                state_d = slt_pkg::S_SCAN_RD;
              end
            end
            slt_pkg::OP_SORT: state_d = slt_pkg::S_SORT_RD;
            slt_pkg::OP_REVERSE: begin
              cmd_o.ab_init = 1'b1;
              state_d = slt_pkg::S_REV_RDA;
            end
            slt_pkg::OP_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.emit = 1'b1; cmd_o.emit_status = slt_pkg::ST_EMPTY;
                cmd_o.emit_last = 1'b1; state_d = slt_pkg::S_IDLE;
              end else begin
                state_d = slt_pkg::S_DUMP_RD;
              end
            end
            default: begin
              cmd_o.emit = 1'b1; cmd_o.emit_last = 1'b1;
              state_d = slt_pkg::S_IDLE;
            end
          endcase
        end
      end
      // Find the first entry not less than the key.
      slt_pkg::S_SCAN_RD: begin
        if (stat_i.scan_done || stat_i.opcode == slt_pkg::OP_APPEND) begin
          if (stat_i.opcode == slt_pkg::OP_APPEND) begin
            // Append places at the tail: move scan to fill count by shifting none.
            state_d = slt_pkg::S_SHIFT_RD;
            cmd_o.scan_inc = !stat_i.shift_done;
          end else begin
            state_d = slt_pkg::S_SHIFT_RD;
          end
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d = slt_pkg::S_SCAN_CMP;
        end
      end
      slt_pkg::S_SCAN_CMP: begin
        if (stat_i.less) begin
          cmd_o.scan_inc = 1'b1;
          state_d = slt_pkg::S_SCAN_RD;
        end else begin
          state_d = slt_pkg::S_SHIFT_RD;
        end
      end
      // Move entries up one place from the end down to the scan point.
      slt_pkg::S_SHIFT_RD: begin
        if (stat_i.opcode == slt_pkg::OP_APPEND && !stat_i.shift_done) begin
          cmd_o.scan_inc = 1'b1;
        end else if (stat_i.shift_done) begin
          state_d = slt_pkg::S_PLACE;
        end else begin
          cmd_o.rd_shift = 1'b1;
          state_d = slt_pkg::S_SHIFT_WR;
        end
      end
      slt_pkg::S_SHIFT_WR: begin
        cmd_o.wr_shift  = 1'b1;
        cmd_o.shift_dec = 1'b1;
        state_d = slt_pkg::S_SHIFT_RD;
      end
      slt_pkg::S_PLACE: begin
        cmd_o.wr_place = 1'b1;
        if (stat_i.opcode == slt_pkg::OP_SORT) begin
          cmd_o.i_inc = 1'b1;
          state_d = slt_pkg::S_SORT_RD;
        end else if (!stat_i.out_busy) begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.emit = 1'b1; cmd_o.emit_last = 1'b1;
          state_d = slt_pkg::S_IDLE;
        end
      end
      // One insertion pass per sort index.
      slt_pkg::S_SORT_RD: begin
        if (stat_i.sort_done) begin
          if (!stat_i.out_busy) begin
            cmd_o.emit = 1'b1; cmd_o.emit_last = 1'b1;
            state_d = slt_pkg::S_IDLE;
          end
        end else begin
          cmd_o.rd_i = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.shift_from_i = 1'b1;
          state_d = slt_pkg::S_SORT_KEY;
        end
      end
      slt_pkg::S_SORT_KEY: begin
        cmd_o.key_from_rd = 1'b1;
        state_d = slt_pkg::S_SCAN_RD;
      end
      // Swap pairs from both ends.
      slt_pkg::S_REV_RDA: begin
        if (stat_i.ab_done) begin
          if (!stat_i.out_busy) begin
            cmd_o.emit = 1'b1; cmd_o.emit_last = 1'b1;
            state_d = slt_pkg::S_IDLE;
          end
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d = slt_pkg::S_REV_RDB;
        end
      end
      slt_pkg::S_REV_RDB: begin
        cmd_o.rd_b = 1'b1;
        cmd_o.tmp_from_rd = 1'b1;
        state_d = slt_pkg::S_REV_WRA;
      end
      slt_pkg::S_REV_WRA: begin
        cmd_o.wr_a_rd = 1'b1;
        state_d = slt_pkg::S_REV_WRB;
      end
      slt_pkg::S_REV_WRB: begin
        cmd_o.wr_b_tmp = 1'b1;
        cmd_o.ab_step  = 1'b1;
        state_d = slt_pkg::S_REV_RDA;
      end
      // Read one entry, then emit it when the output is free.
      slt_pkg::S_DUMP_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d = slt_pkg::S_DUMP_OUT;
      end
      slt_pkg::S_DUMP_OUT: begin
        cmd_o.rd_scan = 1'b1;
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_entry = 1'b1;
          cmd_o.emit_last = stat_i.dump_last;
          if (stat_i.dump_last) begin
            state_d = slt_pkg::S_IDLE;
          end else begin
            cmd_o.scan_inc = 1'b1;
            state_d = slt_pkg::S_DUMP_RD;
          end
        end
      end
      default: state_d = slt_pkg::S_IDLE;
    endcase
  end
endmodule

@@ sv/sorted_list_table.sv @@
// Full appends and inserts, dumps of an empty list and unused opcodes give their result
// straight from decode; other operations first walk the memory, and a dump issues its
// entries one by one as it reads them. One item is handled at a time: the next is
// taken the cycle after the last result of the current one is issued, and output
// stalls delay the results and so the next item.
// Reset clears the entry count, result valid and controller; memory stays undefined.
// ----------------------------------------------------------------------------
// Sorted list table
// Bounded ordered list of signed values with append, sorted insert, sort,
// reverse and dump operations.
// ----------------------------------------------------------------------------
module sorted_list_table #(
  parameter int unsigned Depth = slt_pkg::DefaultDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  slt_if.sink   in_if,
  slt_if.source out_if
);
  slt_pkg::slt_cmd_t  cmd;
  slt_pkg::slt_stat_t stat;

  slt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  slt_datapath #(.Depth(Depth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (in_if.data.opcode),
    .item_value_i  (in_if.data.item_value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .entry_value_o (out_if.data.entry_value),
    .status_o      (out_if.data.status),
    .entry_count_o (out_if.data.entry_count),
    .last_o        (out_if.data.last)
  );
endmodule

@@ sim/sorted_list_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives append, insert, sort, reverse, dump and unused opcodes through the
// input channel. A list model in a small scoreboard predicts every result.
// Both channel sides idle at random over several phases, and one long
// receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module sorted_list_table_tb;

  localparam int unsigned Depth      = slt_pkg::DefaultDepth;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemsPerPhase = 75;
  localparam logic [slt_pkg::OpW-1:0] OpUnusedLo  = 3'd5;
  localparam logic [slt_pkg::OpW-1:0] OpUnusedMid = 3'd6;
  localparam logic [slt_pkg::OpW-1:0] OpUnusedHi  = 3'd7;

  // Scoreboard: holds its own copy of the list and the expected results.
  class list_scoreboard;
    logic signed [slt_pkg::ValW-1:0] entries [Depth];
    int unsigned                     fill;
    slt_pkg::result_t                expected_q[$];
    int unsigned                     errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_result(logic signed [slt_pkg::ValW-1:0] v,
                              slt_pkg::status_e st, logic lst);
      slt_pkg::result_t r;
      r.entry_value = v;
      r.status      = st;
      r.entry_count = fill[slt_pkg::CntW-1:0];
      r.last        = lst;
      expected_q.push_back(r);
    endfunction

    // Insertion point: before the first entry greater than or equal to v.
    function int unsigned find_slot(logic signed [slt_pkg::ValW-1:0] v,
                                    int unsigned lim);
      int unsigned p;
      p = 0;
      while (p < lim && entries[p] < v) p++;
      return p;
    endfunction

    function void note_input(slt_pkg::item_t it);
      int unsigned p;
      int unsigned b;
      logic signed [slt_pkg::ValW-1:0] key;
      case (it.opcode)
        slt_pkg::OP_APPEND, slt_pkg::OP_INSERT: begin
          if (fill >= Depth) begin
            push_result('0, slt_pkg::ST_FULL, 1'b1);
            return;
          end
          p = (it.opcode == slt_pkg::OP_APPEND) ? fill : find_slot(it.item_value, fill);
          for (int unsigned j = fill; j > p; j--) entries[j] = entries[j-1];
          entries[p] = it.item_value;
          fill++;
        end
        slt_pkg::OP_SORT: begin
          for (int unsigned i = 1; i < fill; i++) begin
            key = entries[i];
            p = find_slot(key, i);
            for (int unsigned j = i; j > p; j--) entries[j] = entries[j-1];
            entries[p] = key;
          end
        end
        slt_pkg::OP_REVERSE: begin
          if (fill >= 2) begin
            b = fill - 1;
            for (int unsigned a = 0; a < b; a++, b--) begin
              key = entries[a];
              entries[a] = entries[b];
              entries[b] = key;
            end
          end
        end
        slt_pkg::OP_DUMP: begin
          if (fill == 0) push_result('0, slt_pkg::ST_EMPTY, 1'b1);
          for (int unsigned i = 0; i < fill; i++)
            push_result(entries[i], slt_pkg::ST_OK, i + 1 == fill);
          return;
        end
        default: ;
      endcase
      push_result('0, slt_pkg::ST_OK, 1'b1);
    endfunction

    task check_result(slt_pkg::result_t got);
      slt_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.entry_value !== exp.entry_value)
        report($sformatf("entry_value got %0d exp %0d", got.entry_value, exp.entry_value));
      if (got.status !== exp.status)
        report($sformatf("status got %0d exp %0d", got.status, exp.status));
      if (got.entry_count !== exp.entry_count)
        report($sformatf("entry_count got %0d exp %0d", got.entry_count, exp.entry_count));
      if (got.last !== exp.last)
        report($sformatf("last got %0b exp %0b", got.last, exp.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  slt_if #(.T(slt_pkg::item_t))   in_if ();
  slt_if #(.T(slt_pkg::result_t)) out_if ();

  sorted_list_table #(.Depth(Depth)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  list_scoreboard list_sb = new();
  int unsigned    src_idle_pct;
  int unsigned    snk_stall_pct;
  int unsigned    hold_cycles;
  int unsigned    cycle_cnt;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout watchdog.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, list_sb.expected_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Result monitor: sample between edges, check at the accepting edge.
  initial begin
    logic             took;
    slt_pkg::result_t res;
    forever begin
      @(negedge clk_i);
      took = out_if.valid && out_if.ready && rst_ni;
      res  = out_if.data;
      @(posedge clk_i);
      if (took) list_sb.check_result(res);
    end
  end

  // Offer one item and wait for its transfer.
  task send_item(logic [slt_pkg::OpW-1:0] op, logic signed [slt_pkg::ValW-1:0] v);
    slt_pkg::item_t it;
    logic           rdy;
    it.opcode     = op;
    it.item_value = v;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    list_sb.note_input(it);
  endtask

  function automatic logic signed [slt_pkg::ValW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Random mix: appends and inserts 22 percent each, sorts 16, reverses 14, dumps 20, unused 6.
  task send_random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 22)      send_item(slt_pkg::OP_APPEND, pick_value());
    else if (r < 44) send_item(slt_pkg::OP_INSERT, pick_value());
    else if (r < 60) send_item(slt_pkg::OP_SORT, pick_value());
    else if (r < 74) send_item(slt_pkg::OP_REVERSE, pick_value());
    else if (r < 94) send_item(slt_pkg::OP_DUMP, pick_value());
    else send_item(3'($urandom_range(OpUnusedHi, OpUnusedLo)), pick_value());
  endtask

  task drain();
    in_if.valid <= 1'b0;
    while (list_sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_cycles   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, single entry, extremes, ties, unused opcodes.
    send_item(slt_pkg::OP_DUMP, 0);
    send_item(slt_pkg::OP_SORT, 0);
    send_item(slt_pkg::OP_REVERSE, 0);
    send_item(slt_pkg::OP_APPEND, 32'sh7FFF_FFFF);
    send_item(slt_pkg::OP_SORT, 0);
    send_item(slt_pkg::OP_REVERSE, 0);
    send_item(slt_pkg::OP_INSERT, 32'sh8000_0000);
    send_item(slt_pkg::OP_INSERT, 5);
    send_item(slt_pkg::OP_INSERT, 5);
    send_item(slt_pkg::OP_APPEND, -1);
    send_item(slt_pkg::OP_DUMP, 0);
    send_item(slt_pkg::OP_SORT, 0);
    send_item(slt_pkg::OP_REVERSE, 0);
    send_item(slt_pkg::OP_DUMP, 0);
    send_item(OpUnusedLo, 32'sh5555_5555);
    send_item(OpUnusedMid, 32'shAAAA_AAAA);
    send_item(OpUnusedHi, -1);
    send_item(slt_pkg::OP_DUMP, 0);

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 34; snk_stall_pct = 34; end
      endcase
      // Long receiver hold-off while items keep coming.
      if (ph == 0) hold_cycles = 400;
      for (int unsigned k = 0; k < ItemsPerPhase; k++) send_random_item();
      // The list is full by now: exercise full drops and ordering directly.
      if (ph == 1) begin
        send_item(slt_pkg::OP_APPEND, 1);
        send_item(slt_pkg::OP_INSERT, -1);
        send_item(slt_pkg::OP_SORT, 0);
        send_item(slt_pkg::OP_DUMP, 0);
        send_item(slt_pkg::OP_REVERSE, 0);
        send_item(slt_pkg::OP_DUMP, 0);
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (list_sb.errors == 0 && list_sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
